@@ rtl/core/aat_pkg.sv @@
package aat_pkg;

    localparam int DEPTH        = 16;
    localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RESULT_LIMIT = 16;
    localparam int K_W          = $clog2(RESULT_LIMIT + 1);
    localparam int ALIAS_CHARS  = 10;
    localparam int ALIAS_W      = 8 * ALIAS_CHARS;
    localparam int ADDR_W       = 32;
    localparam int ENTRY_W      = ALIAS_W + ADDR_W;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_UPDATE = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_LOC    = 3'd4;

    typedef enum logic [2:0] {
        SC_OK        = 3'd0,
        SC_ADDR_DUP  = 3'd1,
        SC_ALIAS_DUP = 3'd2,
        SC_NOT_FOUND = 3'd3,
        SC_EMPTY     = 3'd4,
        SC_FULL      = 3'd5,
        SC_BAD_ALIAS = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_ADD,
        PH_FIND,
        PH_ADDR,
        PH_LOC
    } phase_t;

    // bytes after the first zero byte are forced to zero
    function automatic logic [ALIAS_W-1:0] canon(input logic [ALIAS_W-1:0] a);
        logic [ALIAS_W-1:0] r;
        logic               ended;
        r     = '0;
        ended = 1'b0;
        for (int i = 0; i < ALIAS_CHARS; i++) begin
            if (!ended && a[ALIAS_W-1-8*i -: 8] != 8'd0)
                r[ALIAS_W-1-8*i -: 8] = a[ALIAS_W-1-8*i -: 8];
            else
                ended = 1'b1;
        end
        return r;
    endfunction

    // upper case letters fold to lower case
    function automatic logic [ALIAS_W-1:0] fold(input logic [ALIAS_W-1:0] a);
        logic [ALIAS_W-1:0] r;
        logic [7:0]         b;
        r = '0;
        for (int i = 0; i < ALIAS_CHARS; i++) begin
            b = a[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5A)
                b = b + 8'h20;
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/aat_ram.sv @@
module aat_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/alias_address_table_unit.sv @@
// channel  | ports                                              | handshake
// command  | cmd, alias_head, alias_tail, address               | start & !busy
// result   | status, address_out, alias_head_out,               | done, one cycle
//          | alias_tail_out, last                               |
// a command walks the table one entry per cycle through the single read port
// of the entry ram; setup, the registered ram read and the result register add to the walk
// update walks it twice, delete walks from the removed entry to the tail copying
// each entry down one place
// errors on an empty alias or empty table answer the cycle after start
// rst_n clears the entry count and control; ram contents need no reset
// results cannot be stalled; done marks each one for a single cycle
module alias_address_table_unit
    import aat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [63:0] alias_head,
    input  logic [15:0] alias_tail,
    input  logic [31:0] address,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] address_out,
    output logic [63:0] alias_head_out,
    output logic [15:0] alias_tail_out,
    output logic        last
);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [ALIAS_W-1:0]  alias_reg, alias_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    iq_reg, iq_next;
    logic                vq_reg, vq_next;
    logic [CNT_W-1:0]    f_reg, f_next;
    logic [ALIAS_W-1:0]  hold_alias_reg, hold_alias_next;
    logic [ADDR_W-1:0]   hold_addr_reg, hold_addr_next;
    logic                pend_reg, pend_next;
    logic [K_W-1:0]      k_reg, k_next;

    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [ADDR_W-1:0]   aout_reg, aout_next;
    logic [ALIAS_W-1:0]  alout_reg, alout_next;
    logic                last_reg, last_next;

    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [ENTRY_W-1:0]  rdata;

    logic [ALIAS_W-1:0]  ca;
    logic [ALIAS_W-1:0]  e_alias;
    logic [ADDR_W-1:0]   e_addr;
    logic                alias_hit;
    logic                last_entry;

    aat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign ca         = canon({alias_head, alias_tail});
    assign e_alias    = rdata[ENTRY_W-1:ADDR_W];
    assign e_addr     = rdata[ADDR_W-1:0];
    assign alias_hit  = (fold(e_alias) == fold(alias_reg));
    assign last_entry = (iq_reg == count_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            vq_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            vq_reg    <= vq_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg      <= phase_next;
        cmd_reg        <= cmd_next;
        alias_reg      <= alias_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        iq_reg         <= iq_next;
        f_reg          <= f_next;
        hold_alias_reg <= hold_alias_next;
        hold_addr_reg  <= hold_addr_next;
        k_reg          <= k_next;
        status_reg     <= status_next;
        aout_reg       <= aout_next;
        alout_reg      <= alout_next;
        last_reg       <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        alias_next      = alias_reg;
        addr_next       = addr_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        iq_next         = iq_reg;
        vq_next         = 1'b0;
        f_next          = f_reg;
        hold_alias_next = hold_alias_reg;
        hold_addr_next  = hold_addr_reg;
        pend_next       = pend_reg;
        k_next          = k_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        aout_next       = aout_reg;
        alout_next      = alout_reg;
        last_next       = last_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = '0;

        // keep one read in flight while walking
        if ((state_reg == ST_SCAN || state_reg == ST_SHIFT) && idx_reg < count_reg)
        begin
            idx_next = idx_reg + CNT_W'(1);
            iq_next  = idx_reg;
            vq_next  = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && cmd <= CMD_LOC)
                begin
                    cmd_next   = cmd;
                    alias_next = ca;
                    addr_next  = address;
                    idx_next   = '0;
                    vq_next    = 1'b0;
                    pend_next  = 1'b0;
                    k_next     = '0;
                    last_next  = 1'b1;
                    aout_next  = '0;
                    alout_next = '0;
                    if (cmd != CMD_LOC && ca[ALIAS_W-1 -: 8] == 8'd0)
                    begin
                        done_next   = 1'b1;
                        status_next = SC_BAD_ALIAS;
                    end
                    else if (cmd != CMD_ADD && count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = SC_EMPTY;
                    end
                    else if (cmd == CMD_ADD && count_reg == '0)
                    begin
                        we          = 1'b1;
                        waddr       = '0;
                        wdata       = {ca, address};
                        count_next  = CNT_W'(1);
                        done_next   = 1'b1;
                        status_next = SC_OK;
                        aout_next   = address;
                        alout_next  = ca;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        unique case (cmd) inside
                            CMD_ADD:                         phase_next = PH_ADD;
                            CMD_LOC:                         phase_next = PH_LOC;
                            CMD_LOOKUP, CMD_UPDATE, CMD_DELETE: phase_next = PH_FIND;
                            default:                         phase_next = PH_FIND;
                        endcase
                    end
                end
            end

            ST_SCAN:
            begin
                if (vq_reg)
                begin
                    case (phase_reg)
                        PH_ADD:
                        begin
                            if (e_addr == addr_reg || alias_hit)
                            begin
                                state_next  = ST_IDLE;
                                done_next   = 1'b1;
                                status_next = (e_addr == addr_reg) ? SC_ADDR_DUP : SC_ALIAS_DUP;
                                aout_next   = e_addr;
                                alout_next  = e_alias;
                                last_next   = 1'b1;
                            end
                            else if (last_entry)
                            begin
                                state_next = ST_IDLE;
                                done_next  = 1'b1;
                                last_next  = 1'b1;
                                if (count_reg == CNT_W'(DEPTH))
                                begin
                                    status_next = SC_FULL;
                                    aout_next   = '0;
                                    alout_next  = '0;
                                end
                                else
                                begin
                                    we          = 1'b1;
                                    waddr       = count_reg[IDX_W-1:0];
                                    wdata       = {alias_reg, addr_reg};
                                    count_next  = count_reg + CNT_W'(1);
                                    status_next = SC_OK;
                                    aout_next   = addr_reg;
                                    alout_next  = alias_reg;
                                end
                            end
                        end

                        PH_FIND:
                        begin
                            if (alias_hit)
                            begin
                                hold_alias_next = e_alias;
                                hold_addr_next  = e_addr;
                                f_next          = iq_reg;
                                if (cmd_reg == CMD_UPDATE)
                                begin
                                    phase_next = PH_ADDR;
                                    idx_next   = '0;
                                    vq_next    = 1'b0;
                                end
                                else if (cmd_reg == CMD_DELETE && !last_entry)
                                begin
                                    state_next = ST_SHIFT;
                                    idx_next   = iq_reg + CNT_W'(1);
                                    vq_next    = 1'b0;
                                end
                                else
                                begin
                                    if (cmd_reg == CMD_DELETE)
                                        count_next = count_reg - CNT_W'(1);
                                    state_next  = ST_IDLE;
                                    done_next   = 1'b1;
                                    status_next = SC_OK;
                                    aout_next   = e_addr;
                                    alout_next  = e_alias;
                                    last_next   = 1'b1;
                                end
                            end
                            else if (last_entry)
                            begin
                                state_next  = ST_IDLE;
                                done_next   = 1'b1;
                                status_next = SC_NOT_FOUND;
                                aout_next   = '0;
                                alout_next  = '0;
                                last_next   = 1'b1;
                            end
                        end

                        PH_ADDR:
                        begin
                            if (e_addr == addr_reg)
                            begin
                                state_next  = ST_IDLE;
                                done_next   = 1'b1;
                                status_next = SC_ADDR_DUP;
                                aout_next   = e_addr;
                                alout_next  = e_alias;
                                last_next   = 1'b1;
                            end
                            else if (last_entry)
                            begin
                                we          = 1'b1;
                                waddr       = f_reg[IDX_W-1:0];
                                wdata       = {hold_alias_reg, addr_reg};
                                state_next  = ST_IDLE;
                                done_next   = 1'b1;
                                status_next = SC_OK;
                                aout_next   = hold_addr_reg;
                                alout_next  = hold_alias_reg;
                                last_next   = 1'b1;
                            end
                        end

                        PH_LOC:
                        begin
                            if (e_addr[31:16] == addr_reg[31:16])
                            begin
                                // the previous match goes out, this one waits
                                if (pend_reg)
                                begin
                                    done_next   = 1'b1;
                                    status_next = SC_OK;
                                    aout_next   = hold_addr_reg;
                                    alout_next  = hold_alias_reg;
                                    last_next   = 1'b0;
                                end
                                hold_alias_next = e_alias;
                                hold_addr_next  = e_addr;
                                pend_next       = 1'b1;
                                k_next          = k_reg + K_W'(1);
                                if (last_entry || k_reg + K_W'(1) == K_W'(RESULT_LIMIT))
                                    state_next = ST_FLUSH;
                            end
                            else if (last_entry)
                            begin
                                state_next  = ST_IDLE;
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                pend_next   = 1'b0;
                                status_next = pend_reg ? SC_OK : SC_NOT_FOUND;
                                aout_next   = pend_reg ? hold_addr_reg : '0;
                                alout_next  = pend_reg ? hold_alias_reg : '0;
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SHIFT:
            begin
                if (vq_reg)
                begin
                    we    = 1'b1;
                    waddr = IDX_W'(iq_reg - CNT_W'(1));
                    wdata = rdata;
                    if (last_entry)
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        status_next = SC_OK;
                        aout_next   = hold_addr_reg;
                        alout_next  = hold_alias_reg;
                        last_next   = 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = SC_OK;
                aout_next   = hold_addr_reg;
                alout_next  = hold_alias_reg;
                last_next   = 1'b1;
                pend_next   = 1'b0;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign address_out    = aout_reg;
    assign alias_head_out = alout_reg[ALIAS_W-1:16];
    assign alias_tail_out = alout_reg[15:0];
    assign last           = last_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vq_reg |-> iq_reg < count_reg)
        else $error("read of an entry past the tail");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == SC_NOT_FOUND || status_reg == SC_EMPTY ||
                      status_reg == SC_FULL || status_reg == SC_BAD_ALIAS))
        |-> (aout_reg == '0 && alout_reg == '0 && last_reg))
        else $error("error result carries entry data");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(we) || $past(state_reg) != ST_IDLE)
        else $error("entry count changed without table work");
`endif

endmodule
